@@ rtl/wmf_pkg.sv @@
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants of the window median filter: field widths,
// request kinds, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package wmf_pkg;

   localparam int DEF_FRAME_WIDTH  = 256;
   localparam int DEF_FRAME_HEIGHT = 256;
   localparam int DEF_MAX_RADIUS   = 7;

   localparam int POS_W        = 8;     // row and column fields
   localparam int PIX_W        = 8;     // grey level
   localparam int CFG_W        = 3;     // window radius register
   localparam int COORD_W      = 10;    // signed window coordinate
   localparam int GREY_LEVELS  = 256;
   localparam int BIN_W        = 8;

   localparam logic [CFG_W-1:0] RADIUS_RESET = 3'd3;

   typedef enum logic {
      KIND_STORE = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;       // latch query centre and radius
      logic write_px;   // store request pixel
      logic gen_en;     // issue current window position, advance
      logic clear_en;   // zero histogram bin, advance bin counter
      logic scan_en;    // read and zero histogram bin, advance bin counter
   } cmd_type;

   typedef struct packed {
      logic gen_last;   // current window position is the last one
      logic bin_last;   // bin counter at the top bin
      logic pipe_busy;  // window pixels still in flight
   } stat_type;

endpackage

@@ rtl/wmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmf_ctrl
// Sequencer of the median filter: histogram clearing pass after reset, pixel
// stores, window fetch, pipeline drain, histogram scan and result beat.
// ----------------------------------------------------------------------------
module wmf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_kind,
   input  wmf_pkg::stat_type stat,
   output wmf_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);
   import wmf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.bin_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  cmd.write_px = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            cmd.gen_en = 1'b1;
            if (stat.gen_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last histogram update has landed
            if (!stat.pipe_busy) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.bin_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/wmf_datapath.sv @@
// ----------------------------------------------------------------------------
// wmf_datapath
// Frame memory, window address generator, histogram memory with
// read-modify-write forwarding, and the cumulative scan that picks the median.
// ----------------------------------------------------------------------------
module wmf_datapath #(
   parameter int FRAME_WIDTH  = wmf_pkg::DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = wmf_pkg::DEF_FRAME_HEIGHT,
   parameter int MAX_RADIUS   = wmf_pkg::DEF_MAX_RADIUS,
   parameter int RAD_W        = $clog2(MAX_RADIUS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wmf_pkg::cmd_type           cmd,
   input  logic [wmf_pkg::POS_W-1:0]  req_row,
   input  logic [wmf_pkg::POS_W-1:0]  req_col,
   input  logic [wmf_pkg::PIX_W-1:0]  req_pixel_value,
   input  logic [RAD_W-1:0]           radius,
   output wmf_pkg::stat_type          stat,
   output logic [wmf_pkg::PIX_W-1:0]  median_value
);
   import wmf_pkg::*;

   localparam int DEPTH    = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int MAX_SIDE = 2 * MAX_RADIUS + 1;
   localparam int CNT_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int SQ_W     = 2 * (RAD_W + 1);

   // storage
   logic [PIX_W-1:0] frame_mem_ff [DEPTH];
   logic [CNT_W-1:0] hist_mem_ff [GREY_LEVELS];

   // window generator
   logic signed [COORD_W-1:0] r_ff, c_ff, r_hi_ff, c_lo_ff, c_hi_ff;
   logic signed [COORD_W-1:0] row_s, col_s, rad_s;
   logic [CNT_W-1:0]          rank_ff;
   logic [RAD_W:0]            side;
   logic [SQ_W-1:0]           side_sq;

   // fetch pipeline
   logic                      in_frame;
   logic [ADDR_W-1:0]         frd_addr;
   logic [ADDR_W-1:0]         fwr_addr;
   logic                      store_ok;
   logic                      fv1_ff, fin1_ff;
   logic [PIX_W-1:0]          frame_rd_ff;
   logic [PIX_W-1:0]          pix_v;
   logic                      hv2_ff;
   logic [BIN_W-1:0]          v2_ff;
   logic                      wr_valid_ff;
   logic [BIN_W-1:0]          wr_v_ff;
   logic [CNT_W-1:0]          wr_cnt_ff;
   logic [CNT_W-1:0]          cnt_new;

   // histogram port
   logic [BIN_W-1:0]          bin_ff;
   logic [BIN_W-1:0]          hrd_addr;
   logic [CNT_W-1:0]          hist_rd_ff;
   logic                      hwe;
   logic [BIN_W-1:0]          hwa;
   logic [CNT_W-1:0]          hwd;

   // scan
   logic                      scan_v_ff;
   logic [BIN_W-1:0]          bin_d_ff;
   logic [CNT_W-1:0]          seen_ff;
   logic [CNT_W:0]            seen_sum;
   logic                      found_ff;
   logic [PIX_W-1:0]          median_ff;

   assign row_s   = COORD_W'(req_row);
   assign col_s   = COORD_W'(req_col);
   assign rad_s   = COORD_W'(radius);
   assign side    = {radius, 1'b1};
   assign side_sq = SQ_W'(side) * SQ_W'(side);

   // ---------------- window position generator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff    <= row_s - rad_s;
         r_hi_ff <= row_s + rad_s;
         c_ff    <= col_s - rad_s;
         c_lo_ff <= col_s - rad_s;
         c_hi_ff <= col_s + rad_s;
         rank_ff <= CNT_W'(side_sq >> 1);
      end else if (cmd.gen_en) begin
         if (c_ff == c_hi_ff) begin
            c_ff <= c_lo_ff;
            r_ff <= r_ff + COORD_W'(1);
         end else begin
            c_ff <= c_ff + COORD_W'(1);
         end
      end
   end

   assign stat.gen_last = (c_ff == c_hi_ff) && (r_ff == r_hi_ff);

   assign in_frame = (r_ff >= 0) && (int'(r_ff) < FRAME_HEIGHT)
                  && (c_ff >= 0) && (int'(c_ff) < FRAME_WIDTH);
   assign frd_addr = ADDR_W'(ADDR_W'(r_ff[COORD_W-2:0]) * ADDR_W'(FRAME_WIDTH)
                           + ADDR_W'(c_ff[COORD_W-2:0]));

   assign store_ok = (int'(req_row) < FRAME_HEIGHT) && (int'(req_col) < FRAME_WIDTH);
   assign fwr_addr = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(FRAME_WIDTH)
                           + ADDR_W'(req_col));

   // ---------------- frame memory
   always_ff @(posedge clock) begin
      frame_rd_ff <= frame_mem_ff[frd_addr];
      if (cmd.write_px && store_ok) begin
         frame_mem_ff[fwr_addr] <= req_pixel_value;
      end
   end

   // positions outside the frame count as zero
   assign pix_v = fin1_ff ? frame_rd_ff : '0;

   always_ff @(posedge clock) begin
      fin1_ff <= in_frame;
      v2_ff   <= BIN_W'(pix_v);
      wr_v_ff   <= v2_ff;
      wr_cnt_ff <= cnt_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv1_ff      <= 1'b0;
         hv2_ff      <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         fv1_ff      <= cmd.gen_en;
         hv2_ff      <= fv1_ff;
         wr_valid_ff <= hv2_ff;
      end
   end

   assign stat.pipe_busy = fv1_ff || hv2_ff;

   // the read issued on the edge of the previous write misses it: forward
   assign cnt_new = ((wr_valid_ff && (wr_v_ff == v2_ff)) ? wr_cnt_ff : hist_rd_ff)
                    + CNT_W'(1);

   // ---------------- histogram memory
   assign hrd_addr = cmd.scan_en ? bin_ff : BIN_W'(pix_v);
   assign hwe      = cmd.clear_en || cmd.scan_en || hv2_ff;
   assign hwa      = hv2_ff ? v2_ff : bin_ff;
   assign hwd      = hv2_ff ? cnt_new : '0;

   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_mem_ff[hrd_addr];
      if (hwe) begin
         hist_mem_ff[hwa] <= hwd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= '0;
      end else if (cmd.clear_en || cmd.scan_en) begin
         bin_ff <= bin_ff + BIN_W'(1);
      end
   end

   assign stat.bin_last = (bin_ff == BIN_W'(GREY_LEVELS - 1));

   // ---------------- cumulative scan
   assign seen_sum = (CNT_W + 1)'(seen_ff) + (CNT_W + 1)'(hist_rd_ff);

   always_ff @(posedge clock) begin
      bin_d_ff <= bin_ff;
      if (reset) begin
         scan_v_ff <= 1'b0;
         found_ff  <= 1'b0;
         seen_ff   <= '0;
      end else begin
         scan_v_ff <= cmd.scan_en;
         if (cmd.load) begin
            found_ff <= 1'b0;
            seen_ff  <= '0;
         end else if (scan_v_ff) begin
            seen_ff <= seen_sum[CNT_W-1:0];
            if (!found_ff && (seen_sum > (CNT_W + 1)'(rank_ff))) begin
               found_ff  <= 1'b1;
               median_ff <= PIX_W'(bin_d_ff);
            end
         end
      end
   end

   assign median_value = median_ff;

endmodule

@@ rtl/window_median_filter.sv @@
// ----------------------------------------------------------------------------
// window_median_filter
// Two-dimensional median filter with zero padding over a stored frame.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------
//   request  | req_kind req_row req_col req_pixel_value| start high, busy low
//   response | rsp_median_value                        | rsp_strobe, one cycle
//   csr      | csr_write_data (window radius)          | csr_write_enable
//
// A store is written while busy stays low; the next request may follow at once.
// A query keeps busy high while it fetches the side*side window pixels
// (side = 2*radius+1) one after another through the single frame memory
// read port, drains the pipeline and scans the 256 histogram bins.
// After reset a clearing pass over the 256 histogram bins holds busy high.
// The response beat cannot be stalled.
// ----------------------------------------------------------------------------
module window_median_filter #(
   parameter int FRAME_WIDTH  = wmf_pkg::DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = wmf_pkg::DEF_FRAME_HEIGHT,
   parameter int MAX_RADIUS   = wmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_kind,
   input  logic [wmf_pkg::POS_W-1:0]  req_row,
   input  logic [wmf_pkg::POS_W-1:0]  req_col,
   input  logic [wmf_pkg::PIX_W-1:0]  req_pixel_value,
   output logic                       rsp_strobe,
   output logic [wmf_pkg::PIX_W-1:0]  rsp_median_value,
   input  logic                       csr_write_enable,
   input  logic [wmf_pkg::CFG_W-1:0]  csr_write_data
);
   import wmf_pkg::*;

   localparam int RAD_W = $clog2(MAX_RADIUS + 1);

   logic [CFG_W-1:0] radius_ff;
   logic [RAD_W-1:0] radius_sat;
   cmd_type          cmd;
   stat_type         stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_write_enable) begin
         radius_ff <= csr_write_data;
      end
   end

   // clamp the programmed radius to the largest supported window
   assign radius_sat = (int'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                      : RAD_W'(radius_ff);

   wmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_kind),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   wmf_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .MAX_RADIUS   (MAX_RADIUS),
      .RAD_W        (RAD_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_pixel_value (req_pixel_value),
      .radius          (radius_sat),
      .stat            (stat),
      .median_value    (rsp_median_value)
   );

endmodule
